@@ rtl/mts_pkg.sv @@
// Shared types and constants for the memory test sequencer.
package mts_pkg;

    // Geometry of the memory under test.
    localparam int unsigned APERTURE_WORDS = 67108864;
    localparam int unsigned BLOCK_COUNT    = 32;

    // Fixed field widths.
    localparam int unsigned IDX_W    = 26;
    localparam int unsigned BLK_W    = 5;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned WORDS_W  = 27;
    localparam int unsigned TDATA_W  = 136;
    localparam int unsigned WIN_SHIFT = 16;

    // Byte offset between consecutive blocks.
    localparam logic [63:0] BLOCK_BYTES = 64'(APERTURE_WORDS) * 64'd4;
    localparam logic [WORDS_W-1:0] APERTURE_CNT = WORDS_W'(APERTURE_WORDS);
    localparam logic [BLK_W:0]     BLOCK_LIMIT  = (BLK_W+1)'(BLOCK_COUNT);

    localparam logic [WORD_W-1:0] FILL_PATTERN = 32'h5555_5555;

    // Input item kinds.
    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_STEP  = 2'd1,
        KIND_STOP  = 2'd2
    } t_kind;

    // Announced memory operations.
    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_WINDOW = 2'd1,
        OP_WRITE  = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    // Test modes; the unused code behaves as a full pass.
    localparam logic [1:0] MODE_SPOT      = 2'd0;
    localparam logic [1:0] MODE_FULL      = 2'd1;
    localparam logic [1:0] MODE_PERPETUAL = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TEST_MODE  = 2'd0;
    localparam logic [1:0] CFG_SPOT_BLOCK = 2'd1;
    localparam logic [1:0] CFG_SPOT_WORDS = 2'd2;

endpackage

@@ rtl/memory_test_sequencer_core.sv @@
// Top level of the memory test sequencer: session control and operation announcement.
//
// Usage: the input stream (s_axis) carries one item per transfer: tuser holds the kind
// (start, step or stop) and tdata the read data for the read last announced. Every
// accepted item yields exactly one result on the output stream (m_axis): tuser holds
// the next memory operation and tdata the word index, data value, phase, block, pass,
// error count and the finished and stopped flags.
// A start opens a session; each block begins with a window write, then four phases over
// its words (write address, verify, write pattern, verify). Each step confirms the
// announced operation; mismatching reads raise a saturating error count.
// The result of an item is registered: the output register loads it on the item's transfer.
// One item is taken every cycle while the receiver keeps up; the only stored element in the
// path is the state plus the output register, so a new item follows on the next cycle.
// If the receiver stalls, the result is held and s_axis_tready drops until it is taken.
// The configuration channel accepts a write in every cycle; the user must write it only
// while idle, which the block itself does not enforce. Reset clears the session state,
// empties the output register and loads the register defaults (full pass, block 0, whole aperture).
module memory_test_sequencer_core
    import mts_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [1:0]         s_axis_tuser,   // [1:0] kind
    input  logic [WORD_W-1:0]  s_axis_tdata,   // [31:0] read_data
    // Output stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [1:0]         m_axis_tuser,   // [1:0] op
    // [25:0] word_index, [57:26] data_value, [59:58] phase, [64:60] block_number,
    // [96:65] pass_number, [128:97] errors, [129] finished, [130] stopped, rest zero
    output logic [TDATA_W-1:0] m_axis_tdata,
    // Configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [WORD_W-1:0]  i_cfg_data
);

    // Configuration registers.
    logic [1:0]         r_test_mode;
    logic [BLK_W-1:0]   r_spot_block;
    logic [WORDS_W-1:0] r_spot_words;

    // Session state.
    logic               r_running, n_running;
    logic               r_window_pending, n_window_pending;
    logic [1:0]         r_cur_phase, n_cur_phase;
    logic [IDX_W-1:0]   r_cur_index, n_cur_index;
    logic [BLK_W-1:0]   r_cur_block, n_cur_block;
    logic [WORD_W-1:0]  r_pass_count, n_pass_count;
    logic [WORD_W-1:0]  r_error_total, n_error_total;
    logic               r_stop_flag, n_stop_flag;

    // Output register.
    logic               r_out_valid;
    logic [1:0]         r_out_op, n_out_op;
    logic [TDATA_W-1:0] r_out_data, n_out_data;

    logic               in_xfer;
    t_kind              in_kind;
    logic [WORDS_W-1:0] words_per_phase;
    logic [WORD_W-1:0]  cur_expect;
    logic [WORDS_W-1:0] index_inc;
    logic [BLK_W:0]     block_inc;
    logic [IDX_W-1:0]   out_index;
    logic [WORD_W-1:0]  out_value;

    // Byte offset of a block within the address space.
    function automatic logic [63:0] block_offset(input logic [BLK_W-1:0] blk);
        block_offset = 64'(blk) * BLOCK_BYTES;
    endfunction

    // Value written in the current phase and expected back from the read.
    function automatic logic [WORD_W-1:0] expect_value(input logic [1:0] ph,
                                                       input logic [BLK_W-1:0] blk,
                                                       input logic [IDX_W-1:0] idx);
        logic [63:0] offs;
        offs = block_offset(blk);
        if (ph[1]) begin
            expect_value = FILL_PATTERN;
        end else begin
            expect_value = offs[WORD_W-1:0] + WORD_W'({idx, 2'b00});
        end
    endfunction

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign in_kind       = t_kind'(s_axis_tuser);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_op;
    assign m_axis_tdata  = r_out_data;

    // Word count of one phase, read live from the registers.
    always_comb begin
        if (r_test_mode != MODE_SPOT || r_spot_words == '0 || r_spot_words > APERTURE_CNT) begin
            words_per_phase = APERTURE_CNT;
        end else begin
            words_per_phase = r_spot_words;
        end
    end

    assign cur_expect = expect_value(r_cur_phase, r_cur_block, r_cur_index);
    assign index_inc  = {1'b0, r_cur_index} + WORDS_W'(1);
    assign block_inc  = {1'b0, r_cur_block} + (BLK_W+1)'(1);

    // Next session state for the item on the input.
    always_comb begin
        n_running        = r_running;
        n_window_pending = r_window_pending;
        n_cur_phase      = r_cur_phase;
        n_cur_index      = r_cur_index;
        n_cur_block      = r_cur_block;
        n_pass_count     = r_pass_count;
        n_error_total    = r_error_total;
        n_stop_flag      = r_stop_flag;
        unique case (in_kind)
            KIND_START: begin
                if (r_test_mode == MODE_SPOT && {1'b0, r_spot_block} >= BLOCK_LIMIT) begin
                    n_running = 1'b0;
                end else begin
                    n_running        = 1'b1;
                    n_stop_flag      = 1'b0;
                    n_error_total    = '0;
                    n_pass_count     = WORD_W'(1);
                    n_cur_block      = (r_test_mode == MODE_SPOT) ? r_spot_block : '0;
                    n_cur_phase      = '0;
                    n_cur_index      = '0;
                    n_window_pending = 1'b1;
                end
            end
            KIND_STEP: begin
                if (r_running && r_window_pending) begin
                    n_window_pending = 1'b0;
                end else if (r_running) begin
                    // Compare the read data on verify phases.
                    if (r_cur_phase[0] && s_axis_tdata != cur_expect
                        && r_error_total != '1) begin
                        n_error_total = r_error_total + WORD_W'(1);
                    end
                    if (index_inc >= words_per_phase) begin
                        n_cur_index = '0;
                        if (r_cur_phase != 2'd3) begin
                            n_cur_phase = r_cur_phase + 2'd1;
                        end else if (r_test_mode == MODE_SPOT) begin
                            n_running = 1'b0;
                        end else if (block_inc < BLOCK_LIMIT) begin
                            n_cur_block      = block_inc[BLK_W-1:0];
                            n_cur_phase      = '0;
                            n_window_pending = 1'b1;
                        end else if (r_test_mode == MODE_PERPETUAL) begin
                            n_pass_count     = r_pass_count + WORD_W'(1);
                            n_cur_block      = '0;
                            n_cur_phase      = '0;
                            n_window_pending = 1'b1;
                        end else begin
                            n_running = 1'b0;
                        end
                    end else begin
                        n_cur_index = index_inc[IDX_W-1:0];
                    end
                end
            end
            KIND_STOP: begin
                if (r_running) begin
                    n_running   = 1'b0;
                    n_stop_flag = 1'b1;
                end
            end
            default: begin
                // Unused kind: state is kept and the announcement repeats.
            end
        endcase
    end

    // Announcement built from the next state.
    always_comb begin
        logic [63:0] offs;
        offs      = block_offset(n_cur_block);
        n_out_op  = OP_NONE;
        out_index = '0;
        out_value = '0;
        if (n_running && n_window_pending) begin
            n_out_op  = OP_WINDOW;
            out_value = offs[WIN_SHIFT +: WORD_W];
        end else if (n_running) begin
            n_out_op  = n_cur_phase[0] ? OP_READ : OP_WRITE;
            out_index = n_cur_index;
            out_value = expect_value(n_cur_phase, n_cur_block, n_cur_index);
        end
        n_out_data = {5'b0, n_stop_flag, !n_running, n_error_total, n_pass_count,
                      n_cur_block, n_cur_phase, out_value, out_index};
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_test_mode  <= MODE_FULL;
            r_spot_block <= '0;
            r_spot_words <= APERTURE_CNT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TEST_MODE:  r_test_mode  <= i_cfg_data[1:0];
                CFG_SPOT_BLOCK: r_spot_block <= i_cfg_data[BLK_W-1:0];
                CFG_SPOT_WORDS: r_spot_words <= i_cfg_data[WORDS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Session state, updated on every input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running        <= 1'b0;
            r_window_pending <= 1'b0;
            r_cur_phase      <= '0;
            r_cur_index      <= '0;
            r_cur_block      <= '0;
            r_pass_count     <= '0;
            r_error_total    <= '0;
            r_stop_flag      <= 1'b0;
        end else if (in_xfer) begin
            r_running        <= n_running;
            r_window_pending <= n_window_pending;
            r_cur_phase      <= n_cur_phase;
            r_cur_index      <= n_cur_index;
            r_cur_block      <= n_cur_block;
            r_pass_count     <= n_pass_count;
            r_error_total    <= n_error_total;
            r_stop_flag      <= n_stop_flag;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_op   <= n_out_op;
            r_out_data <= n_out_data;
        end
    end

    // An idle session announces no operation.
    a_idle_no_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[129]) |-> (m_axis_tuser == OP_NONE))
        else $error("operation announced while the session is finished");

    // A block always starts its window write at word zero of phase zero.
    a_window_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_running && r_window_pending) |-> (r_cur_index == '0 && r_cur_phase == '0))
        else $error("window write pending in the middle of a block");

    // Without a start, the error count never falls.
    a_errors_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_xfer && in_kind == KIND_START) |=> (r_error_total >= $past(r_error_total)))
        else $error("error count fell without a start");

    // An empty output register never blocks the input.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_axis_tready)
        else $error("input stalled with an empty output register");

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the memory test sequencer core.
`timescale 1ns / 100ps

module tb_top;
    import mts_pkg::*;

    // Codes that the package leaves unnamed.
    localparam logic [1:0] KIND_UNDEFINED = 2'd3;
    localparam logic [1:0] MODE_UNDEFINED = 2'd3;

    // One announcement, unpacked into its fields.
    typedef struct packed {
        logic [1:0]  op;
        logic [25:0] word_index;
        logic [31:0] data_value;
        logic [1:0]  phase;
        logic [4:0]  blk_num;
        logic [31:0] pass_number;
        logic [31:0] errors;
        logic        finished;
        logic        stopped;
    } t_seq_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [1:0]          s_axis_tuser = KIND_STEP;
    logic [WORD_W-1:0]   s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [1:0]          m_axis_tuser;
    logic [TDATA_W-1:0]  m_axis_tdata;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [1:0]          i_cfg_index = CFG_TEST_MODE;
    logic [WORD_W-1:0]   i_cfg_data = '0;

    // Register copies, at their reset values.
    logic [1:0]          mode_reg       = MODE_FULL;
    logic [BLK_W-1:0]    spot_block_reg = '0;
    logic [WORDS_W-1:0]  spot_words_reg = APERTURE_CNT;

    // Session state of the predictor.
    logic                run_active   = 1'b0;
    logic                window_due   = 1'b0;
    logic [1:0]          seq_phase    = '0;
    logic [IDX_W-1:0]    seq_index    = '0;
    logic [BLK_W-1:0]    seq_block    = '0;
    logic [31:0]         seq_pass     = '0;
    logic [31:0]         seq_errors   = '0;
    logic                seq_stopped  = 1'b0;

    t_seq_result         pending_announcements[$];
    t_seq_result         last_announce = '0;
    int unsigned         mismatch_count = 0;
    int unsigned         items_sent = 0;
    bit                  tx_idle_on = 1'b0;
    bit                  rx_idle_on = 1'b0;
    int unsigned         rx_wait = 0;
    int unsigned         rx_hold = 0;

    memory_test_sequencer_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // Byte offset of the block under test, before any wrap.
    function automatic logic [63:0] block_byte_offset();
        return 64'(seq_block) * BLOCK_BYTES;
    endfunction

    // Value written in the current phase, and so expected back from a read.
    function automatic logic [31:0] address_or_pattern();
        if (seq_phase < 2'd2)
            return 32'(block_byte_offset() + 64'(seq_index) * 64'd4);
        return FILL_PATTERN;
    endfunction

    // Words per phase; spot sizes of zero or above the aperture mean the aperture.
    function automatic logic [WORDS_W-1:0] words_per_phase();
        if (mode_reg != MODE_SPOT)
            return APERTURE_CNT;
        if (spot_words_reg == '0 || spot_words_reg > APERTURE_CNT)
            return APERTURE_CNT;
        return spot_words_reg;
    endfunction

    function automatic void open_block(logic [BLK_W-1:0] blk);
        seq_block  = blk;
        seq_phase  = 2'd0;
        seq_index  = '0;
        window_due = 1'b1;
    endfunction

    // Move on to the next block, the next pass, or end the session.
    function automatic void close_block();
        if (mode_reg == MODE_SPOT) begin
            run_active = 1'b0;
        end else if (32'(seq_block) + 32'd1 < BLOCK_COUNT) begin
            open_block(seq_block + 1'b1);
        end else if (mode_reg == MODE_PERPETUAL) begin
            seq_pass = seq_pass + 32'd1;
            open_block('0);
        end else begin
            run_active = 1'b0;
        end
    endfunction

    // A step confirms the announced operation and checks read data.
    function automatic void confirm_operation(logic [31:0] rd);
        logic [WORDS_W-1:0] next_index;
        if (window_due) begin
            window_due = 1'b0;
        end else begin
            if (seq_phase[0] && rd != address_or_pattern() && seq_errors != '1)
                seq_errors = seq_errors + 32'd1;
            next_index = WORDS_W'(seq_index) + 1'b1;
            if (next_index >= words_per_phase()) begin
                seq_index = '0;
                if (seq_phase == 2'd3)
                    close_block();
                else
                    seq_phase = seq_phase + 2'd1;
            end else begin
                seq_index = next_index[IDX_W-1:0];
            end
        end
    endfunction

    // Apply one item to the predictor and return the announcement it causes.
    function automatic t_seq_result predict_item(logic [1:0] kind, logic [31:0] rd);
        t_seq_result res;
        case (kind)
            KIND_START: begin
                if (mode_reg == MODE_SPOT && {1'b0, spot_block_reg} >= BLOCK_LIMIT) begin
                    run_active = 1'b0;
                end else begin
                    run_active  = 1'b1;
                    seq_stopped = 1'b0;
                    seq_errors  = '0;
                    seq_pass    = 32'd1;
                    open_block(mode_reg == MODE_SPOT ? spot_block_reg : '0);
                end
            end
            KIND_STEP: begin
                if (run_active)
                    confirm_operation(rd);
            end
            KIND_STOP: begin
                if (run_active) begin
                    run_active  = 1'b0;
                    seq_stopped = 1'b1;
                end
            end
            default: ;
        endcase
        res = '0;
        if (run_active) begin
            if (window_due) begin
                res.op         = OP_WINDOW;
                res.data_value = 32'(block_byte_offset() >> WIN_SHIFT);
            end else begin
                res.op         = seq_phase[0] ? OP_READ : OP_WRITE;
                res.word_index = seq_index;
                res.data_value = address_or_pattern();
            end
        end
        res.phase       = seq_phase;
        res.blk_num     = seq_block;
        res.pass_number = seq_pass;
        res.errors      = seq_errors;
        res.finished    = ~run_active;
        res.stopped     = seq_stopped;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------

    // Offer one item and wait for its transfer; valid stays high afterwards.
    task automatic send_item(logic [1:0] kind, logic [31:0] rd);
        int unsigned gap;
        gap = tx_idle_on ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= rd;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        last_announce = predict_item(kind, rd);
        pending_announcements.push_back(last_announce);
        items_sent++;
    endtask

    // Step with the read data that the last announcement asks for, or a corrupted word.
    task automatic step_item(bit corrupt);
        logic [31:0] rd;
        rd = $urandom;
        if (last_announce.op == OP_READ && !corrupt)
            rd = last_announce.data_value;
        else if (last_announce.op == OP_READ && rd == last_announce.data_value)
            rd = ~rd;
        send_item(KIND_STEP, rd);
    endtask

    // Stop offering and wait until every expected announcement has arrived.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_announcements.size() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    // Register write, only ever made while the block is idle.
    task automatic write_register(logic [1:0] index, logic [31:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (index)
            CFG_TEST_MODE:  mode_reg       = value[1:0];
            CFG_SPOT_BLOCK: spot_block_reg = value[BLK_W-1:0];
            CFG_SPOT_WORDS: spot_words_reg = value[WORDS_W-1:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Receiver: a random wait after each transfer, and an optional long hold.
    always @(posedge i_clk) begin
        if (m_axis_tvalid === 1'b1 && m_axis_tready)
            rx_wait = rx_idle_on ? $urandom_range(0, 7) : 0;
        if (rx_hold != 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else if (rx_wait != 0) begin
            rx_wait--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : announcement_check
        t_seq_result want;
        t_seq_result got;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            got.op          = m_axis_tuser;
            got.word_index  = m_axis_tdata[25:0];
            got.data_value  = m_axis_tdata[57:26];
            got.phase       = m_axis_tdata[59:58];
            got.blk_num     = m_axis_tdata[64:60];
            got.pass_number = m_axis_tdata[96:65];
            got.errors      = m_axis_tdata[128:97];
            got.finished    = m_axis_tdata[129];
            got.stopped     = m_axis_tdata[130];
            if (pending_announcements.size() == 0) begin
                $error("unexpected transfer on the output stream");
                mismatch_count++;
            end else begin
                want = pending_announcements.pop_front();
                check_field("op", 32'(want.op), 32'(got.op));
                check_field("word_index", 32'(want.word_index), 32'(got.word_index));
                check_field("data_value", want.data_value, got.data_value);
                check_field("phase", 32'(want.phase), 32'(got.phase));
                check_field("block_number", 32'(want.blk_num), 32'(got.blk_num));
                check_field("pass_number", want.pass_number, got.pass_number);
                check_field("errors", want.errors, got.errors);
                check_field("finished", 32'(want.finished), 32'(got.finished));
                check_field("stopped", 32'(want.stopped), 32'(got.stopped));
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Steps, stops and undefined kinds with no session running.
    task automatic test_idle_items();
        send_item(KIND_STEP, 32'hFFFF_FFFF);
        send_item(KIND_STOP, 32'h0000_0000);
        send_item(KIND_UNDEFINED, 32'hA5A5_A5A5);
    endtask

    // Full pass: window write, an ignored kind, a restart and a stop.
    task automatic test_full_start_and_stop();
        write_register(CFG_TEST_MODE, 32'(MODE_FULL));
        send_item(KIND_START, $urandom);
        step_item(1'b0);
        send_item(KIND_UNDEFINED, $urandom);
        send_item(KIND_START, $urandom);
        send_item(KIND_STOP, $urandom);
        step_item(1'b0);
    endtask

    // One-word spot test on the top block, which wraps the address value.
    task automatic test_spot_session();
        write_register(CFG_TEST_MODE, 32'(MODE_SPOT));
        write_register(CFG_SPOT_BLOCK, 32'd31);
        write_register(CFG_SPOT_WORDS, 32'd1);
        send_item(KIND_START, $urandom);
        step_item(1'b0);
        send_item(KIND_STEP, 32'h0000_0000);
        send_item(KIND_STEP, 32'hFFFF_FFFF);
        send_item(KIND_STEP, 32'hFFFF_FFFF);
        step_item(1'b0);
    endtask

    // Spot sizes of zero and beyond the aperture fall back to the aperture.
    task automatic test_spot_size_limits();
        write_register(CFG_SPOT_WORDS, 32'd0);
        send_item(KIND_START, $urandom);
        step_item(1'b0);
        send_item(KIND_STOP, $urandom);
        write_register(CFG_SPOT_WORDS, 32'(APERTURE_CNT) * 2 - 1);
        send_item(KIND_START, $urandom);
        step_item(1'b0);
        send_item(KIND_STOP, $urandom);
    endtask

    // The unused mode code and the perpetual mode.
    task automatic test_other_modes();
        write_register(CFG_TEST_MODE, 32'(MODE_UNDEFINED));
        send_item(KIND_START, $urandom);
        send_item(KIND_STOP, $urandom);
        write_register(CFG_TEST_MODE, 32'(MODE_PERPETUAL));
        send_item(KIND_START, $urandom);
        step_item(1'b0);
        send_item(KIND_STOP, $urandom);
    endtask

    // The receiver holds off for a long stretch while items keep coming.
    task automatic test_output_backpressure();
        write_register(CFG_TEST_MODE, 32'(MODE_SPOT));
        write_register(CFG_SPOT_WORDS, 32'd3);
        tx_idle_on = 1'b0;
        rx_hold    = 200;
        send_item(KIND_START, $urandom);
        repeat (12) step_item(1'b0);
        if (run_active)
            send_item(KIND_STOP, $urandom);
    endtask

    // New random settings between sessions, mostly small spot tests.
    task automatic choose_settings();
        int unsigned r;
        if ($urandom_range(0, 1) != 0) begin
            r = $urandom_range(0, 9);
            write_register(CFG_TEST_MODE, r < 7 ? 32'(MODE_SPOT) :
                                          r == 7 ? 32'(MODE_FULL) :
                                          r == 8 ? 32'(MODE_PERPETUAL) : 32'(MODE_UNDEFINED));
        end
        if ($urandom_range(0, 1) != 0)
            write_register(CFG_SPOT_BLOCK, $urandom_range(0, 31));
        if ($urandom_range(0, 1) != 0) begin
            r = $urandom_range(0, 19);
            write_register(CFG_SPOT_WORDS, r < 15 ? $urandom_range(1, 6) :
                                           r < 18 ? $urandom_range(7, 40) :
                                           r == 18 ? 32'd0 :
                                           $urandom_range(32'(APERTURE_CNT) + 1,
                                                          32'(APERTURE_CNT) * 2 - 1));
        end
    endtask

    // One session with random content: mostly good steps, some noise.
    task automatic run_session();
        int unsigned steps;
        int unsigned r;
        steps = 0;
        send_item(KIND_START, $urandom);
        while (run_active && steps < 120) begin
            r = $urandom_range(0, 99);
            if (r < 2)
                send_item(KIND_UNDEFINED, $urandom);
            else if (r == 2)
                send_item(KIND_STOP, $urandom);
            else if (r == 3)
                send_item(KIND_START, $urandom);
            else
                step_item(r < 12);
            steps++;
        end
        if (run_active)
            send_item(KIND_STOP, $urandom);
        r = $urandom_range(0, 7);
        if (r == 0)
            send_item(KIND_STEP, $urandom);
        else if (r == 1)
            send_item(KIND_STOP, $urandom);
        else if (r == 2)
            send_item(KIND_UNDEFINED, $urandom);
    endtask

    task automatic test_random_sessions();
        while (items_sent < 1650) begin
            if ($urandom_range(0, 2) == 0)
                choose_settings();
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            run_session();
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence of tests
    // ---------------------------------------------------------------

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        test_idle_items();
        test_full_start_and_stop();
        test_spot_session();
        test_spot_size_limits();
        test_other_modes();
        test_output_backpressure();
        test_random_sessions();
        drain_results();
        repeat (5) @(posedge i_clk);
        if (mismatch_count == 0 && pending_announcements.size() == 0) begin
            $display("memory_test_sequencer_core: match");
        end else begin
            $display("memory_test_sequencer_core: mismatch");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #2_000_000;
        $display("memory_test_sequencer_core: mismatch");
        $finish;
    end

endmodule
